>>> hw/rtl/mpd_pkg.sv
`timescale 1ns / 1ps

package mpd_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SQ = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH  = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLOFF   = 8'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEL     = 8'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_EN   = 8'd7;
    localparam int CFG_DATA_W = 64;

    // falloff codes
    localparam logic [1:0] FO_NONE = 2'd0;
    localparam logic [1:0] FO_INV_SQ = 2'd1;
    localparam logic [1:0] FO_INV_D = 2'd2;
    localparam logic [1:0] FO_INV_SQRT_D = 2'd3;

    // fixed datapath widths
    localparam int RSQ_W = 62;    // radius squared, Q30.32
    localparam int STR_W = 32;    // strength and weight
    localparam int AD_KEEP = 31;  // axis distance bits kept when near
    localparam int D2_W = 64;     // squared distance, Q32.32
    localparam int AM_W = 63;     // |strength * weight|, Q31.32
    localparam int S_W = 32;      // sqrt(d2), Q16.16
    localparam int R_W = 24;      // fourth root of d2, Q8.16
    localparam int NUM_W = 79;    // widest dividend (am << 16)

endpackage

>>> hw/rtl/mpd_sqrt_cell.sv
`timescale 1ns / 1ps

// One restoring square-root step: settles one root bit per cell.
module mpd_sqrt_cell #(
    parameter int K = 32,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [K:0]        i_rem,
    input  logic [K-1:0]      i_root,
    input  logic [2*K-1:0]    i_opnd,
    input  logic [SIDE_W-1:0] i_side,
    output logic [K:0]        o_rem,
    output logic [K-1:0]      o_root,
    output logic [2*K-1:0]    o_opnd,
    output logic [SIDE_W-1:0] o_side
);

    logic [K+2:0] w_rt;
    logic [K+2:0] w_trial;
    logic         w_ge;
    logic [K:0]   n_rem;

    // bring down two operand bits and try root*4+1
    assign w_rt    = {i_rem, i_opnd[2*K-1 -: 2]};
    assign w_trial = {1'b0, i_root, 2'b01};
    assign w_ge    = (w_rt >= w_trial);
    assign n_rem   = w_ge ? (K+1)'(w_rt - w_trial) : (K+1)'(w_rt);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= n_rem;
            o_root <= {i_root[K-2:0], w_ge};
            o_opnd <= {i_opnd[2*K-3:0], 2'b00};
            o_side <= i_side;
        end
    end

endmodule

>>> hw/rtl/mpd_div_cell.sv
`timescale 1ns / 1ps

// One restoring division step: settles one quotient bit per cell.
module mpd_div_cell #(
    parameter int DW = 64,
    parameter int QW = 33,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [DW-1:0]     i_rem,
    input  logic [QW-1:0]     i_num,
    input  logic [QW-1:0]     i_q,
    input  logic [DW-1:0]     i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic [DW-1:0]     o_rem,
    output logic [QW-1:0]     o_num,
    output logic [QW-1:0]     o_q,
    output logic [DW-1:0]     o_den,
    output logic [SIDE_W-1:0] o_side
);

    logic [DW:0]   w_rt;
    logic          w_ge;
    logic [DW-1:0] n_rem;

    // shift in the next dividend bit, subtract divisor if it fits
    assign w_rt  = {i_rem, i_num[QW-1]};
    assign w_ge  = (w_rt >= {1'b0, i_den});
    assign n_rem = w_ge ? DW'(w_rt - {1'b0, i_den}) : DW'(w_rt);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= n_rem;
            o_num  <= {i_num[QW-2:0], 1'b0};
            o_q    <= {i_q[QW-2:0], w_ge};
            o_den  <= i_den;
            o_side <= i_side;
        end
    end

endmodule

>>> hw/rtl/magnet_point_displace.sv
`timescale 1ns / 1ps

// Magnet displacement of mesh vertices.
// Slave stream: one vertex per request, tdata = px, py, pz, weight from the lowest bit,
// coordinates COORD_WIDTH bits signed Q16.16, weight 32 bits signed Q16.16.
// Master stream: tdata = qx, qy, qz from the lowest bit, tuser = in_range.
// Configuration: i_cfg_valid/o_cfg_ready with register index and 64-bit data; always ready.
// Write it only while no vertex is in flight.
// Throughput: one vertex per cycle while the output buffer is not full. The path from
// acceptance to the result on the master side runs through three front stages
// (distance, multiply, sum), a 32-cell square-root chain, a 24-cell fourth-root chain,
// a divisor set-up stage, a (COORD_WIDTH+1)-cell divider chain, and the output
// buffer.
// The pipeline advances as one; a two-entry output buffer keeps taking results while the
// receiver stalls, and the slave side is held off only once that buffer is full.
// Reset (synchronous, active low) empties the pipeline and buffer and restores register
// defaults: centres 0, radius_sq 0, strength 1.0, falloff none, attract, all axes on.
module magnet_point_displace
    import mpd_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // px, py, pz, weight from bit 0 up, zero padded to bytes
    input  logic [((3*COORD_WIDTH+STR_W+7)/8)*8-1:0] i_s_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // qx, qy, qz from bit 0 up, zero padded to bytes
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0] o_m_tdata,
    // in_range
    output logic                 o_m_tuser,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = COORD_WIDTH;
    localparam int QW = CW + 1;
    localparam int OUT_TW = ((3*CW+7)/8)*8;
    localparam int AD_W = (CW + 1 > 32) ? CW + 1 : 32;
    localparam int ST_SQ1 = 3;
    localparam int ST_SQ2 = ST_SQ1 + S_W;
    localparam int ST_SET = ST_SQ2 + R_W;
    localparam int ST_DIV = ST_SET + 1;
    localparam int NST = ST_DIV + QW;
    localparam int SIDE1_W = 3*CW + AM_W + 2 + D2_W;
    localparam int SIDE2_W = SIDE1_W + S_W;
    localparam int SIDE3_W = 3*CW + 4;
    localparam int RES_W = 3*CW + 1;

    // configuration registers
    logic [CW-1:0]    r_cx, r_cy, r_cz;
    logic [RSQ_W-1:0] r_rsq;
    logic [STR_W-1:0] r_strength;
    logic [1:0]       r_falloff;
    logic             r_repel;
    logic [2:0]       r_axis;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx       <= '0;
            r_cy       <= '0;
            r_cz       <= '0;
            r_rsq      <= '0;
            r_strength <= STR_W'(65536);
            r_falloff  <= FO_NONE;
            r_repel    <= 1'b0;
            r_axis     <= 3'b111;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CENTER_X:  r_cx <= i_cfg_data[CW-1:0];
                CFG_CENTER_Y:  r_cy <= i_cfg_data[CW-1:0];
                CFG_CENTER_Z:  r_cz <= i_cfg_data[CW-1:0];
                CFG_RADIUS_SQ: r_rsq <= i_cfg_data[RSQ_W-1:0];
                CFG_STRENGTH:  r_strength <= i_cfg_data[STR_W-1:0];
                CFG_FALLOFF:   r_falloff <= i_cfg_data[1:0];
                CFG_REPEL:     r_repel <= i_cfg_data[0];
                CFG_AXIS_EN:   r_axis <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // pipeline control: one advance for all stages
    logic           w_adv;
    logic [NST-1:0] r_v;
    logic [1:0]     r_cnt;

    assign w_adv = (r_cnt != 2'd2) || i_m_tready;
    assign o_s_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[NST-2:0], i_s_tvalid};
        end
    end

    // stage 0: axis differences and far test
    logic [CW-1:0]      w_pin [3];
    logic [CW-1:0]      w_cen [3];
    logic [3*CW-1:0]    r_a_p;
    logic [STR_W-1:0]   r_a_w;
    logic [AD_KEEP-1:0] r_a_ad [3];
    logic               r_a_far;
    logic [AD_W-1:0]    w_diff [3];
    logic [AD_W-1:0]    w_ad [3];
    logic [2:0]         w_far;

    assign w_pin[0] = i_s_tdata[CW-1:0];
    assign w_pin[1] = i_s_tdata[2*CW-1:CW];
    assign w_pin[2] = i_s_tdata[3*CW-1:2*CW];
    assign w_cen[0] = r_cx;
    assign w_cen[1] = r_cy;
    assign w_cen[2] = r_cz;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_diff[k] = {{(AD_W-CW){w_pin[k][CW-1]}}, w_pin[k]}
                      - {{(AD_W-CW){w_cen[k][CW-1]}}, w_cen[k]};
            w_ad[k]   = w_diff[k][AD_W-1] ? AD_W'(-w_diff[k]) : w_diff[k];
            w_far[k]  = |w_ad[k][AD_W-1:AD_KEEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_p   <= i_s_tdata[3*CW-1:0];
            r_a_w   <= i_s_tdata[3*CW+STR_W-1:3*CW];
            for (int k = 0; k < 3; k++) begin
                r_a_ad[k] <= w_ad[k][AD_KEEP-1:0];
            end
            r_a_far <= |w_far;
        end
    end

    // stage 1: squares and strength * weight
    logic [2*AD_KEEP-1:0] w_sq [3];
    logic signed [63:0]   w_m;
    logic [2*AD_KEEP-1:0] r_b_sq [3];
    logic signed [63:0]   r_b_m;
    logic [3*CW-1:0]      r_b_p;
    logic                 r_b_far;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sq[k] = r_a_ad[k] * r_a_ad[k];
        end
    end
    assign w_m = $signed(r_strength) * $signed(r_a_w);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_sq  <= w_sq;
            r_b_m   <= w_m;
            r_b_p   <= r_a_p;
            r_b_far <= r_a_far;
        end
    end

    // stage 2: distance sum, range test, magnitude of product
    logic [D2_W-1:0]    w_d2;
    logic               w_inr;
    logic [AM_W-1:0]    w_am;
    logic [D2_W-1:0]    r_c_d2;
    logic [SIDE1_W-1:0] r_c_side;

    assign w_d2 = {2'b00, r_b_sq[0]} + {2'b00, r_b_sq[1]} + {2'b00, r_b_sq[2]};
    assign w_inr = !r_b_far && (w_d2 <= {2'b00, r_rsq});
    assign w_am = r_b_m[63] ? AM_W'(-r_b_m) : AM_W'(r_b_m);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_d2   <= w_d2;
            r_c_side <= {r_b_p, w_am, r_b_m[63], w_inr, w_d2};
        end
    end

    // square root of d2: one cell per root bit
    logic [S_W:0]       w_s1_rem  [S_W+1];
    logic [S_W-1:0]     w_s1_root [S_W+1];
    logic [2*S_W-1:0]   w_s1_opnd [S_W+1];
    logic [SIDE1_W-1:0] w_s1_side [S_W+1];

    assign w_s1_rem[0]  = '0;
    assign w_s1_root[0] = '0;
    assign w_s1_opnd[0] = r_c_d2;
    assign w_s1_side[0] = r_c_side;

    for (genvar j = 0; j < S_W; j++) begin : g_sq1
        mpd_sqrt_cell #(.K(S_W), .SIDE_W(SIDE1_W)) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_rem  (w_s1_rem[j]),
            .i_root (w_s1_root[j]),
            .i_opnd (w_s1_opnd[j]),
            .i_side (w_s1_side[j]),
            .o_rem  (w_s1_rem[j+1]),
            .o_root (w_s1_root[j+1]),
            .o_opnd (w_s1_opnd[j+1]),
            .o_side (w_s1_side[j+1])
        );
    end

    // fourth root: square root of s << 16
    logic [R_W:0]       w_s2_rem  [R_W+1];
    logic [R_W-1:0]     w_s2_root [R_W+1];
    logic [2*R_W-1:0]   w_s2_opnd [R_W+1];
    logic [SIDE2_W-1:0] w_s2_side [R_W+1];

    assign w_s2_rem[0]  = '0;
    assign w_s2_root[0] = '0;
    assign w_s2_opnd[0] = {w_s1_root[S_W], 16'h0000};
    assign w_s2_side[0] = {w_s1_side[S_W], w_s1_root[S_W]};

    for (genvar j = 0; j < R_W; j++) begin : g_sq2
        mpd_sqrt_cell #(.K(R_W), .SIDE_W(SIDE2_W)) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_rem  (w_s2_rem[j]),
            .i_root (w_s2_root[j]),
            .i_opnd (w_s2_opnd[j]),
            .i_side (w_s2_side[j]),
            .o_rem  (w_s2_rem[j+1]),
            .o_root (w_s2_root[j+1]),
            .o_opnd (w_s2_opnd[j+1]),
            .o_side (w_s2_side[j+1])
        );
    end

    // divisor set-up: pick dividend and divisor, flag the special cases
    logic [3*CW-1:0]  w_f_p;
    logic [AM_W-1:0]  w_f_am;
    logic             w_f_neg;
    logic             w_f_inr;
    logic [D2_W-1:0]  w_f_d2;
    logic [S_W-1:0]   w_f_s;
    logic [R_W-1:0]   w_f_r;
    logic [NUM_W-1:0] w_num;
    logic [D2_W-1:0]  w_den;
    logic             w_fzero;
    logic             w_fcap;
    logic [NUM_W-1:0] w_num_hi;
    logic             w_ovf;
    logic [D2_W-1:0]  r_g_rem;
    logic [QW-1:0]    r_g_num;
    logic [D2_W-1:0]  r_g_den;
    logic [SIDE3_W-1:0] r_g_side;

    assign {w_f_p, w_f_am, w_f_neg, w_f_inr, w_f_d2, w_f_s} = w_s2_side[R_W];
    assign w_f_r   = w_s2_root[R_W];
    assign w_fzero = (r_falloff != FO_NONE) && (w_f_am == '0);
    assign w_fcap  = (r_falloff != FO_NONE) && (w_f_am != '0) && (w_f_d2 == '0);

    always_comb begin
        case (r_falloff)
            FO_NONE: begin
                w_num = NUM_W'(w_f_am);
                w_den = D2_W'(65536);
            end
            FO_INV_SQ: begin
                w_num = {w_f_am, 16'h0000};
                w_den = w_f_d2;
            end
            FO_INV_D: begin
                w_num = NUM_W'(w_f_am);
                w_den = D2_W'(w_f_s);
            end
            default: begin
                w_num = NUM_W'(w_f_am);
                w_den = D2_W'(w_f_r);
            end
        endcase
        if (w_fzero || w_fcap) begin
            w_num = '0;
            w_den = D2_W'(1);
        end
    end

    assign w_num_hi = w_num >> QW;
    assign w_ovf    = (w_num_hi >= NUM_W'(w_den));

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_g_rem  <= w_num_hi[D2_W-1:0];
            r_g_num  <= w_num[QW-1:0];
            r_g_den  <= w_den;
            r_g_side <= {w_f_p, w_f_neg, w_f_inr, w_fzero, w_fcap || w_ovf};
        end
    end

    // divider chain: one cell per quotient bit
    logic [D2_W-1:0]    w_dv_rem  [QW+1];
    logic [QW-1:0]      w_dv_num  [QW+1];
    logic [QW-1:0]      w_dv_q    [QW+1];
    logic [D2_W-1:0]    w_dv_den  [QW+1];
    logic [SIDE3_W-1:0] w_dv_side [QW+1];

    assign w_dv_rem[0]  = r_g_rem;
    assign w_dv_num[0]  = r_g_num;
    assign w_dv_q[0]    = '0;
    assign w_dv_den[0]  = r_g_den;
    assign w_dv_side[0] = r_g_side;

    for (genvar j = 0; j < QW; j++) begin : g_div
        mpd_div_cell #(.DW(D2_W), .QW(QW), .SIDE_W(SIDE3_W)) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_rem  (w_dv_rem[j]),
            .i_num  (w_dv_num[j]),
            .i_q    (w_dv_q[j]),
            .i_den  (w_dv_den[j]),
            .i_side (w_dv_side[j]),
            .o_rem  (w_dv_rem[j+1]),
            .o_num  (w_dv_num[j+1]),
            .o_q    (w_dv_q[j+1]),
            .o_den  (w_dv_den[j+1]),
            .o_side (w_dv_side[j+1])
        );
    end

    // final: cap, sign, add to enabled axes and saturate
    localparam logic [QW-1:0] V_CAP = QW'(1) << CW;
    logic [3*CW-1:0]  w_h_p;
    logic             w_h_neg;
    logic             w_h_inr;
    logic             w_h_zero;
    logic             w_h_cap;
    logic [QW-1:0]    w_mag;
    logic signed [CW+1:0] w_v;
    logic signed [CW+1:0] w_sum [3];
    logic [CW-1:0]    w_q [3];
    logic [RES_W-1:0] w_res;

    assign {w_h_p, w_h_neg, w_h_inr, w_h_zero, w_h_cap} = w_dv_side[QW];

    always_comb begin
        if (w_h_zero) begin
            w_mag = '0;
        end else if (w_h_cap || (w_dv_q[QW] > V_CAP)) begin
            w_mag = V_CAP;
        end else begin
            w_mag = w_dv_q[QW];
        end
        w_v = (w_h_neg ^ r_repel) ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
        for (int k = 0; k < 3; k++) begin
            w_sum[k] = $signed({{2{w_h_p[k*CW+CW-1]}}, w_h_p[k*CW +: CW]}) + w_v;
            if (!w_h_inr || !r_axis[k]) begin
                w_q[k] = w_h_p[k*CW +: CW];
            end else if (w_sum[k] > $signed({3'b000, {(CW-1){1'b1}}})) begin
                w_q[k] = {1'b0, {(CW-1){1'b1}}};
            end else if (w_sum[k] < $signed({3'b111, {(CW-1){1'b0}}})) begin
                w_q[k] = {1'b1, {(CW-1){1'b0}}};
            end else begin
                w_q[k] = w_sum[k][CW-1:0];
            end
        end
        w_res = {w_h_inr, w_q[2], w_q[1], w_q[0]};
    end

    // two-entry output buffer
    logic             w_push;
    logic             w_pop;
    logic [RES_W-1:0] r_head;
    logic [RES_W-1:0] r_tail;

    assign w_push = r_v[NST-1] && w_adv;
    assign w_pop  = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            case (r_cnt)
                2'd0: if (w_push) r_cnt <= 2'd1;
                2'd1: if (w_push && !w_pop) r_cnt <= 2'd2;
                      else if (!w_push && w_pop) r_cnt <= 2'd0;
                2'd2: if (w_pop && !w_push) r_cnt <= 2'd1;
                default: r_cnt <= 2'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_cnt)
            2'd0: if (w_push) r_head <= w_res;
            2'd1: begin
                if (w_push && w_pop) r_head <= w_res;
                else if (w_push) r_tail <= w_res;
            end
            2'd2: begin
                if (w_pop) r_head <= r_tail;
                if (w_pop && w_push) r_tail <= w_res;
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = (r_cnt != 2'd0);
    assign o_m_tdata  = OUT_TW'(r_head[3*CW-1:0]);
    assign o_m_tuser  = r_head[3*CW];

    // checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("output buffer count out of bounds");
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_cnt == 2'd2 && !i_m_tready))
        else $error("input stalled with room in output buffer");
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_v[0]) else $error("accepted request lost");
    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> o_m_tvalid) else $error("finished result not presented");

endmodule

>>> sim/magnet_point_displace_checker.sv
`timescale 1ns / 1ps

module magnet_point_displace_checker
    import mpd_pkg::*;
#(
    parameter int CW = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    input  logic [((3*CW+STR_W+7)/8)*8-1:0]   i_s_tdata,
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    input  logic [((3*CW+7)/8)*8-1:0]         i_m_tdata,
    input  logic                              i_m_tuser,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]              i_cfg_index,
    input  logic [CFG_DATA_W-1:0]             i_cfg_data,
    output int                                o_errors,
    output int                                o_pending
);

    typedef struct packed {
        logic [CW-1:0] qx;
        logic [CW-1:0] qy;
        logic [CW-1:0] qz;
        logic          in_range;
    } t_vertex_out;

    logic signed [CW-1:0] centre [3];
    logic [RSQ_W-1:0]     rsq;
    logic signed [31:0]   power;
    logic [1:0]           fo;
    logic                 push_away;
    logic [2:0]           axes;

    t_vertex_out displaced_q[$];

    function automatic logic [127:0] isqrt128(logic [127:0] v);
        logic [127:0] r, b;
        r = 0;
        b = 128'd1 << 126;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // displacement of one vertex under the current magnet settings
    function automatic t_vertex_out displace(logic [((3*CW+STR_W+7)/8)*8-1:0] d);
        t_vertex_out res;
        logic signed [CW+1:0] p [3];
        logic signed [CW+1:0] diff;
        logic [CW+1:0]        ad;
        logic [127:0]         d2, am, mag, s, den, cap;
        logic signed [63:0]   m;
        logic signed [129:0]  v, q, lim;
        logic                 far;
        far = 0;
        d2 = 0;
        for (int k = 0; k < 3; k++) begin
            p[k] = $signed(d[k*CW +: CW]);
            diff = p[k] - centre[k];
            ad = diff < 0 ? -diff : diff;
            if (ad >= (128'd1 << 31)) far = 1;
            else d2 = d2 + ad * ad;
        end
        if (far || d2 > rsq) begin
            res.qx = d[0 +: CW];
            res.qy = d[CW +: CW];
            res.qz = d[2*CW +: CW];
            res.in_range = 1'b0;
            return res;
        end
        cap = 128'd1 << CW;
        m = 64'(power) * 64'($signed(d[3*CW +: 32]));
        am = m < 0 ? 128'(-m) : 128'(m);
        if (fo == FO_NONE) mag = am >> 16;
        else if (am == 0) mag = 0;
        else if (d2 == 0) mag = cap;
        else if (fo == FO_INV_SQ) mag = (am << 16) / d2;
        else begin
            s = isqrt128(d2);
            den = (fo == FO_INV_D) ? s : isqrt128(s << 16);
            mag = den == 0 ? cap : am / den;
        end
        if (mag > cap) mag = cap;
        v = (m < 0) ? -$signed({2'b0, mag}) : $signed({2'b0, mag});
        if (push_away) v = -v;
        lim = 130'sd1 <<< (CW - 1);
        for (int k = 0; k < 3; k++) begin
            q = p[k];
            if (axes[k]) begin
                q = q + v;
                if (q > lim - 1) q = lim - 1;
                if (q < -lim) q = -lim;
            end
            case (k)
                0: res.qx = q[CW-1:0];
                1: res.qy = q[CW-1:0];
                default: res.qz = q[CW-1:0];
            endcase
        end
        res.in_range = 1'b1;
        return res;
    endfunction

    assign o_pending = displaced_q.size();

    always @(posedge i_clk) begin
        t_vertex_out want, got;
        if (!i_rst_n) begin
            centre[0] <= '0;
            centre[1] <= '0;
            centre[2] <= '0;
            rsq <= '0;
            power <= 32'sd65536;
            fo <= FO_NONE;
            push_away <= 1'b0;
            axes <= 3'd7;
            o_errors <= 0;
            displaced_q.delete();
        end else begin
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CENTER_X:  centre[0] <= i_cfg_data[CW-1:0];
                    CFG_CENTER_Y:  centre[1] <= i_cfg_data[CW-1:0];
                    CFG_CENTER_Z:  centre[2] <= i_cfg_data[CW-1:0];
                    CFG_RADIUS_SQ: rsq <= i_cfg_data[RSQ_W-1:0];
                    CFG_STRENGTH:  power <= i_cfg_data[31:0];
                    CFG_FALLOFF:   fo <= i_cfg_data[1:0];
                    CFG_REPEL:     push_away <= i_cfg_data[0];
                    CFG_AXIS_EN:   axes <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) displaced_q.push_back(displace(i_s_tdata));
            // compare results
            if (i_m_tvalid && i_m_tready) begin
                got.qx = i_m_tdata[0 +: CW];
                got.qy = i_m_tdata[CW +: CW];
                got.qz = i_m_tdata[2*CW +: CW];
                got.in_range = i_m_tuser;
                if (displaced_q.size() == 0) begin
                    $error("result with none expected");
                    o_errors <= o_errors + 1;
                end else begin
                    want = displaced_q.pop_front();
                    if (got !== want) o_errors <= o_errors + 1;
                    if (got.qx !== want.qx)
                        $error("qx expected %h got %h", want.qx, got.qx);
                    if (got.qy !== want.qy)
                        $error("qy expected %h got %h", want.qy, got.qy);
                    if (got.qz !== want.qz)
                        $error("qz expected %h got %h", want.qz, got.qz);
                    if (got.in_range !== want.in_range)
                        $error("in_range expected %b got %b", want.in_range, got.in_range);
                end
            end
        end
    end

endmodule

>>> sim/magnet_point_displace_tb.sv
`timescale 1ns / 1ps

module magnet_point_displace_tb;
    import mpd_pkg::*;

    localparam int CW = 32;
    localparam int LATENCY = 94;
    localparam int SD_W = ((3*CW+STR_W+7)/8)*8;
    localparam int MD_W = ((3*CW+7)/8)*8;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [SD_W-1:0] s_data = '0;
    logic m_valid;
    logic m_ready = 0;
    logic [MD_W-1:0] m_data;
    logic m_user;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int errors, pending;
    int idle_pct = 22;
    bit hold_sink = 0;
    bit done = 0;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    magnet_point_displace #(.COORD_WIDTH(CW)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_valid), .o_s_tready(s_ready), .i_s_tdata(s_data),
        .o_m_tvalid(m_valid), .i_m_tready(m_ready), .o_m_tdata(m_data), .o_m_tuser(m_user),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    magnet_point_displace_checker #(.CW(CW)) u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_valid), .i_s_tready(s_ready), .i_s_tdata(s_data),
        .i_m_tvalid(m_valid), .i_m_tready(m_ready), .i_m_tdata(m_data), .i_m_tuser(m_user),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver: random stalls, or held off entirely on request
    always @(negedge i_clk) begin
        m_ready <= !hold_sink && ($urandom_range(99) >= idle_pct);
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // one vertex request; valid stays up between back-to-back requests
    task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                               logic [31:0] w);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= {w, z, y, x};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    function automatic logic [31:0] near_coord(logic [31:0] c, int span);
        return c + $signed($urandom_range(2 * span) - span);
    endfunction

    function automatic logic [31:0] any_word();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    logic [31:0] cx, cy, cz;
    int span;

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: defaults (radius 0), then wide radius with each falloff, then repel and axis enables
        send_vertex(0, 0, 0, 32'h00010000);
        send_vertex(1, 0, 0, 32'h00010000);
        send_vertex(32'h7fffffff, 32'h80000000, 0, 32'h7fffffff);
        drain();
        write_reg(CFG_RADIUS_SQ, 64'h3fffffffffffffff);
        write_reg(CFG_STRENGTH, 64'h7fffffff);
        for (int f = 0; f < 4; f++) begin
            write_reg(CFG_FALLOFF, 64'(f));
            send_vertex(0, 0, 0, 32'h7fffffff);
            send_vertex(0, 0, 0, 0);
            send_vertex(32'h00010000, 0, 0, 32'h80000000);
            send_vertex(32'h7fff0000, 32'h7fff0000, 32'h7fff0000, 32'h7fffffff);
            send_vertex(32'h80010000, 32'h80000000, 0, 32'hffffffff);
            drain();
        end
        write_reg(CFG_REPEL, 64'd1);
        write_reg(CFG_AXIS_EN, 64'd0);
        send_vertex(32'h00001000, 0, 0, 32'h00010000);
        drain();
        write_reg(CFG_AXIS_EN, 64'd5);
        write_reg(CFG_STRENGTH, 64'h80000000);
        send_vertex(32'h7ffffff0, 5, 32'h80000010, 32'h80000000);
        drain();

        // random phases, each with its own magnet setting
        for (int ph = 0; ph < 16; ph++) begin
            cx = any_word();
            cy = ($urandom_range(1)) ? $urandom : 0;
            cz = $urandom_range(1) ? 32'h80000000 : $urandom;
            span = (ph % 3 == 0) ? 32'h7fffffff : (1 << $urandom_range(4, 30));
            write_reg(CFG_CENTER_X, {32'h0, cx});
            write_reg(CFG_CENTER_Y, {32'h0, cy});
            write_reg(CFG_CENTER_Z, {32'h0, cz});
            write_reg(CFG_RADIUS_SQ, (ph == 5) ? 64'h0 :
                      {$urandom, $urandom} >> $urandom_range(2, 30));
            write_reg(CFG_STRENGTH, {32'h0, any_word()});
            write_reg(CFG_FALLOFF, 64'(ph % 4));
            write_reg(CFG_REPEL, 64'($urandom_range(1)));
            write_reg(CFG_AXIS_EN, 64'($urandom_range(7)));
            write_reg(CFG_IDX_W'(8 + $urandom_range(200)), {$urandom, $urandom});
            idle_pct = (ph == 7) ? 0 : 22;
            if (ph == 3) begin
                // long receiver hold-off while requests keep coming
                fork
                    begin
                        hold_sink = 1;
                        repeat (300) @(negedge i_clk);
                        hold_sink = 0;
                    end
                join_none
            end
            for (int n = 0; n < 100; n++) begin
                if ($urandom_range(9) == 0)
                    send_vertex($urandom, $urandom, $urandom, any_word());
                else
                    send_vertex(near_coord(cx, span), near_coord(cy, span),
                                near_coord(cz, span), any_word());
            end
            drain();
        end
        done = 1;
    end

    initial begin
        wait (done);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/mpd_pkg.sv
hw/rtl/mpd_sqrt_cell.sv
hw/rtl/mpd_div_cell.sv
hw/rtl/magnet_point_displace.sv
sim/magnet_point_displace_checker.sv
sim/magnet_point_displace_tb.sv
